/* hw/rtl/rlps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlps_pkg
// Shared types and constants for the raster laser power segmenter.
// ----------------------------------------------------------------------------
package rlps_pkg;

    // configuration port shape
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_LOWER_LEVEL  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_UPPER_LEVEL  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_DIRECT       = 3'd2;
    localparam logic [CFG_AW-1:0] REG_PIXEL_WIDTH  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SCALE_DIV    = 3'd4;

    // field widths
    localparam int LEVEL_W = 8;
    localparam int PW_W    = 16;
    localparam int SC_W    = 7;
    localparam int ENDX_W  = 28;

    // register reset values and substitutes for zero
    localparam logic [LEVEL_W-1:0] LOWER_RESET = 8'd1;
    localparam logic [LEVEL_W-1:0] UPPER_RESET = 8'd100;
    localparam logic [PW_W-1:0]    PW_DEFAULT  = 16'd1000;
    localparam logic [SC_W-1:0]    SC_DEFAULT  = 7'd1;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* hw/rtl/rlps_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlps_div
// Restoring divider by a 7-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rlps_div
    import rlps_pkg::*;
#(
    parameter int DW = 29
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DW-1:0]       i_dividend,
    input  logic [SC_W-1:0]     i_divisor,
    output t_div_stat           o_stat,
    output logic [DW-1:0]       o_quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    r_quo;
    logic [SC_W-1:0]  r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [SC_W:0]    w_trial;
    logic             w_ge;
    logic [SC_W:0]    w_diff;

    // one trial subtraction per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[DW-1]};
        w_ge    = (w_trial >= {1'b0, i_divisor});
        w_diff  = w_trial - {1'b0, i_divisor};
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[SC_W-1:0] : w_trial[SC_W-1:0];
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

    // a new division never starts over a running one
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_cnt == '0))
        else $error("divider started while busy");

    // done follows the final iteration
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CNT_W'(1) && !i_start) |=> r_done)
        else $error("divider done missing");

endmodule

/* hw/rtl/raster_laser_power_segmenter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_laser_power_segmenter_core
// Maps RGB pixels to laser power levels and emits a segment whenever the level
// changes within a row, plus a closing segment at a row end of nonzero level.
// ----------------------------------------------------------------------------
// Sequence: a pixel with no segment passes the accept, level and decide states.
// A segment adds mul, div and emit; the bit-serial divider forms DW quotient bits,
// DW = clog2(MAX_WIDTH)+17 (29 at MAX_WIDTH 4096). Two segments run in turn, as
// both coordinates share the divider. A stalled output holds the sequencer in
// emit and adds its wait. A new pixel is taken only in the idle state.
// Reset is synchronous active low: control and row state clear, no clearing pass.
// ----------------------------------------------------------------------------
module raster_laser_power_segmenter_core
    import rlps_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel input stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [23:0]       i_s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic              i_s_tlast,   // last_in_row
    // segment output stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [39:0]       o_m_tdata,   // end_x[27:0], power_level[35:28], zero pad
    output logic              o_m_tuser,   // row_close
    output logic              o_m_tlast,   // last result of the pixel
    // configuration writes
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int DW = CW + 1 + PW_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEVEL,
        S_DECIDE,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

    // configuration registers
    logic [LEVEL_W-1:0] r_lower;
    logic [LEVEL_W-1:0] r_upper;
    logic               r_direct;
    logic [PW_W-1:0]    r_pw;
    logic [SC_W-1:0]    r_sc;

    // sequencer and row state
    t_state             r_state;
    logic [CW-1:0]      r_column;
    logic [LEVEL_W-1:0] r_prev;
    logic               r_started;

    // per-pixel working registers
    logic [LEVEL_W-1:0] r_bright;
    logic               r_row_end;
    logic [15:0]        r_num;
    logic [LEVEL_W-1:0] r_p;
    logic [LEVEL_W-1:0] r_seg_pow;
    logic               r_seg;
    logic               r_close;
    logic [CW-1:0]      r_col_base;

    // output register
    logic               r_out_valid;
    logic [39:0]        r_out_data;
    logic               r_out_user;
    logic               r_out_last;

    // combinational helpers
    logic [7:0]          w_max;
    logic signed [8:0]   w_diff;
    logic signed [17:0]  w_prod;
    logic signed [17:0]  w_num;
    logic [16:0]         w_div255;
    logic [LEVEL_W-1:0]  w_level;
    logic                w_seg;
    logic                w_close;
    logic [CW:0]         w_pos;
    logic [PW_W-1:0]     w_pw_eff;
    logic [SC_W-1:0]     w_sc_eff;
    logic [DW-1:0]       w_dividend;
    logic [DW+ENDX_W-1:0] w_quo_ext;
    logic                w_accept;
    logic                w_load;

    t_div_stat           w_div_stat;
    logic [DW-1:0]       w_quotient;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower  <= LOWER_RESET;
            r_upper  <= UPPER_RESET;
            r_direct <= 1'b0;
            r_pw     <= PW_DEFAULT;
            r_sc     <= SC_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_LOWER_LEVEL: r_lower  <= i_cfg_wdata[LEVEL_W-1:0];
                REG_UPPER_LEVEL: r_upper  <= i_cfg_wdata[LEVEL_W-1:0];
                REG_DIRECT:      r_direct <= i_cfg_wdata[0];
                REG_PIXEL_WIDTH: r_pw     <= i_cfg_wdata[PW_W-1:0];
                REG_SCALE_DIV:   r_sc     <= i_cfg_wdata[SC_W-1:0];
                default: ;
            endcase
        end
    end

    // brightness is the largest component
    always_comb begin
        w_max = i_s_tdata[7:0];
        if (i_s_tdata[15:8] > w_max) w_max = i_s_tdata[15:8];
        if (i_s_tdata[23:16] > w_max) w_max = i_s_tdata[23:16];
    end

    // linear map numerator: lower*255 + b*(upper-lower), never negative
    always_comb begin
        w_diff = $signed({1'b0, r_upper}) - $signed({1'b0, r_lower});
        w_prod = 18'($signed({1'b0, r_bright}) * w_diff);
        w_num  = $signed({2'b00, ({r_lower, 8'd0} - {8'd0, r_lower})}) + w_prod;
    end

    // divide by 255 through x + x/256 + 1, exact for the numerator range
    always_comb begin
        w_div255 = {1'b0, r_num} + {9'd0, r_num[15:8]} + 17'd1;
        w_level  = w_div255[15:8];
        w_seg    = r_started && (w_level != r_prev);
        w_close  = r_row_end && (w_level != '0);
    end

    // coordinate product, zero registers replaced by their defaults
    always_comb begin
        w_pw_eff   = (r_pw == '0) ? PW_DEFAULT : r_pw;
        w_sc_eff   = (r_sc == '0) ? SC_DEFAULT : r_sc;
        w_pos      = r_seg ? {1'b0, r_col_base} : ({1'b0, r_col_base} + 1'b1);
        w_dividend = {{PW_W{1'b0}}, w_pos} * {{(CW + 1){1'b0}}, w_pw_eff};
        w_quo_ext  = {{ENDX_W{1'b0}}, w_quotient};
    end

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_load   = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);

    // shared coordinate divider
    rlps_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_MUL),
        .i_dividend (w_dividend),
        .i_divisor  (w_sc_eff),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    // sequencer, row state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_column    <= '0;
            r_prev      <= '0;
            r_started   <= 1'b0;
            r_seg       <= 1'b0;
            r_close     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_bright  <= r_direct ? w_max : ~w_max;
                        r_row_end <= i_s_tlast;
                        r_state   <= S_LEVEL;
                    end
                end
                S_LEVEL: begin
                    r_num   <= w_num[15:0];
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_p        <= w_level;
                    r_seg_pow  <= r_prev;
                    r_seg      <= w_seg;
                    r_close    <= w_close;
                    r_col_base <= r_column;
                    if (r_row_end) begin
                        r_column  <= '0;
                        r_prev    <= '0;
                        r_started <= 1'b0;
                    end else begin
                        r_prev    <= w_level;
                        r_started <= 1'b1;
                        if (r_column < CW'(MAX_WIDTH - 1)) begin
                            r_column <= r_column + 1'b1;
                        end
                    end
                    r_state <= (w_seg || w_close) ? S_MUL : S_IDLE;
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {4'd0, (r_seg ? r_seg_pow : r_p),
                                        w_quo_ext[ENDX_W-1:0]};
                        r_out_user  <= !r_seg;
                        r_out_last  <= r_seg ? !r_close : 1'b1;
                        if (r_seg && r_close) begin
                            r_seg   <= 1'b0;
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

    // one pixel at a time: input closes right after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("input accepted during pixel work");

    // divider completes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV))
        else $error("divider done outside wait state");

    // while waiting, the divider is either running or just finished
    a_div_wait_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (w_div_stat.busy || w_div_stat.done))
        else $error("sequencer waits on an idle divider");

    // a closing segment always ends the pixel's results
    a_close_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("closing segment not marked last");

    // an unstarted row carries no open level
    a_row_reset_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_prev == '0))
        else $error("open level without started row");

endmodule
